// ===== design/fau_pkg.sv =====
// fau_pkg: widths, pipeline stage record and step functions of the fraction arithmetic unit
// no dependencies; imported by fraction_arithmetic_unit
`default_nettype none
package fau_pkg;

  localparam int Width   = 16;
  localparam int DenW    = Width - 1;
  localparam int KW      = (DenW > 2) ? $clog2(DenW) : 2;
  localparam int GcdIt   = 2 * DenW;
  localparam int NumStg  = GcdIt + DenW + 2;
  localparam int ResNumW = 32;
  localparam int ResDenW = 31;
  localparam int PW      = 2 * (Width + 1);
  localparam int ExtW    = PW + ResNumW;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [Width-1:0] an;
    logic [DenW-1:0]         ad;
    logic signed [Width-1:0] bn;
    logic [DenW-1:0]         bd;
    logic                    zero;
    logic [KW-1:0]           k;
    logic [DenW-1:0]         u;
    logic [DenW-1:0]         v;
    logic [DenW-1:0]         qa;
    logic [DenW-1:0]         qb;
    logic [DenW:0]           ra;
    logic [DenW:0]           rb;
  } stage_t;

  function automatic logic [KW-1:0] ctz(input logic [DenW-1:0] x);
    logic [KW-1:0] c;
    c = '0;
    for (int i = DenW - 1; i >= 0; i--) begin
      if (x[i]) c = KW'(i);
    end
    return c;
  endfunction

  function automatic stage_t prep(input cmd_e cmd, input logic signed [Width-1:0] an,
                                  input logic [DenW-1:0] ad, input logic signed [Width-1:0] bn,
                                  input logic [DenW-1:0] bd);
    stage_t s;
    s      = '0;
    s.cmd  = cmd;
    s.an   = an;
    s.ad   = ad;
    s.bn   = bn;
    s.bd   = bd;
    s.zero = (ad == '0) || (bd == '0);
    s.k    = ctz(ad | bd);
    s.u    = ad >> ctz(ad);
    s.v    = bd;
    if (s.zero) begin
      s.u = DenW'(1);
      s.v = '0;
    end
    return s;
  endfunction

  // one binary gcd iteration: make v odd, order, subtract
  function automatic stage_t gcd_step(input stage_t p);
    stage_t s;
    logic [DenW-1:0] vo;
    s  = p;
    vo = p.v >> ctz(p.v);
    if (p.v != '0) begin
      if (p.u > vo) begin
        s.u = vo;
        s.v = p.u - vo;
      end else begin
        s.v = vo - p.u;
      end
    end
    return s;
  endfunction

  function automatic stage_t g_step(input stage_t p);
    stage_t s;
    s    = p;
    s.u  = p.u << p.k;
    s.qa = '0;
    s.qb = '0;
    s.ra = '0;
    s.rb = '0;
    return s;
  endfunction

  // one restoring divide bit for bd/g and ad/g
  function automatic stage_t div_step(input stage_t p, input int bit_i);
    stage_t s;
    logic [DenW:0] ta;
    logic [DenW:0] tb;
    s  = p;
    ta = {p.ra[DenW-1:0], p.bd[bit_i]};
    tb = {p.rb[DenW-1:0], p.ad[bit_i]};
    if (ta >= {1'b0, p.u}) begin
      ta          = ta - {1'b0, p.u};
      s.qa[bit_i] = 1'b1;
    end
    if (tb >= {1'b0, p.u}) begin
      tb          = tb - {1'b0, p.u};
      s.qb[bit_i] = 1'b1;
    end
    s.ra = ta;
    s.rb = tb;
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/fraction_arithmetic_unit.sv =====
// fraction_arithmetic_unit: unreduced fraction add, subtract, multiply and divide
// registered stages in order: prep, 2*DenW binary gcd steps, lcm scale, DenW divide bits,
// multiply, result; throughput: one transfer per cycle, the whole pipeline stalls together
// when the result register is full and not taken
// reset clears the valid bits only; depends on fau_pkg
`default_nettype none
module fraction_arithmetic_unit import fau_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic [1:0]              command_i,
  input  wire logic signed [Width-1:0] a_num_i,
  input  wire logic [DenW-1:0]         a_den_i,
  input  wire logic signed [Width-1:0] b_num_i,
  input  wire logic [DenW-1:0]         b_den_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic signed [ResNumW-1:0] res_num_o,
  output      logic signed [ResDenW-1:0] res_den_o
);

  stage_t stg_q [NumStg];
  logic   vld_q [NumStg];
  logic   en;

  logic signed [PW-1:0] m1_q, m2_q, m3_q;
  cmd_e                 mcmd_q;
  logic                 mvld_q;
  logic                 ovld_q;
  logic signed [ResNumW-1:0] rn_q;
  logic signed [ResDenW-1:0] rd_q;

  assign en         = !ovld_q || out_ready_i;
  assign in_ready_o = en;

  for (genvar s = 0; s < NumStg; s++) begin : g_stg
    stage_t st_d;
    always_comb begin
      if (s == 0) begin
        st_d = prep(cmd_e'(command_i), a_num_i, a_den_i, b_num_i, b_den_i);
      end else if (s <= GcdIt) begin
        st_d = gcd_step(stg_q[(s > 0) ? s - 1 : 0]);
      end else if (s == GcdIt + 1) begin
        st_d = g_step(stg_q[(s > 0) ? s - 1 : 0]);
      end else begin
        st_d = div_step(stg_q[(s > 0) ? s - 1 : 0], DenW - 1 - (s - GcdIt - 2));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= (s == 0) ? in_valid_i : vld_q[(s > 0) ? s - 1 : 0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) stg_q[s] <= st_d;
    end
  end

  stage_t last;
  logic [DenW-1:0] sa, sb;
  logic signed [Width:0] x1, y1, x2, y2, x3, y3;
  assign last = stg_q[NumStg-1];
  assign sa   = last.zero ? '0 : last.qa;
  assign sb   = last.zero ? '0 : last.qb;

  always_comb begin
    x1 = {last.an[Width-1], last.an};
    x2 = {last.bn[Width-1], last.bn};
    y2 = {2'b00, sb};
    x3 = {2'b00, last.ad};
    case (last.cmd)
      CmdMul: begin
        y1 = {last.bn[Width-1], last.bn};
        y3 = {2'b00, last.bd};
      end
      CmdDiv: begin
        y1 = {2'b00, last.bd};
        y3 = {last.bn[Width-1], last.bn};
      end
      default: begin
        y1 = {2'b00, sa};
        y3 = {2'b00, sa};
      end
    endcase
  end

  logic signed [ExtW-1:0] e1, e2, e3, esum;
  assign e1 = ExtW'(m1_q);
  assign e2 = ExtW'(m2_q);
  assign e3 = ExtW'(m3_q);
  always_comb begin
    case (mcmd_q)
      CmdAdd:  esum = e1 + e2;
      CmdSub:  esum = e1 - e2;
      default: esum = e1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else if (en) begin
      mvld_q <= vld_q[NumStg-1];
      ovld_q <= mvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= x1 * y1;
      m2_q   <= x2 * y2;
      m3_q   <= x3 * y3;
      mcmd_q <= last.cmd;
      rn_q   <= esum[ResNumW-1:0];
      rd_q   <= e3[ResDenW-1:0];
    end
  end

  assign out_valid_o = ovld_q;
  assign res_num_o   = rn_q;
  assign res_den_o   = rd_q;

  // gcd loop has converged by its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[GcdIt] && !stg_q[GcdIt].zero |-> stg_q[GcdIt].v == '0)
    else $error("gcd not converged");

  // the gcd divides both denominators exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStg-1] && !last.zero |-> last.ra == '0 && last.rb == '0)
    else $error("lcm scale has remainder");

  // a valid result register is held while it is not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !out_ready_i |=> ovld_q && $stable(rn_q) && $stable(rd_q))
    else $error("result lost under stall");

endmodule
`default_nettype wire
